// ===== src/obrb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obrb_pkg
// Shared types and constants of the overwriting byte ring buffer.
// ----------------------------------------------------------------------------
package obrb_pkg;

	localparam int CAP_W      = 9;
	localparam int BYTE_W     = 8;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 2;

	localparam logic [CAP_W-1:0]      CAP_RESET = 9'd256;
	localparam logic [APB_ADDR_W-1:0] ADDR_CAPACITY = 2'd0;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_GET   = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic exec;
		logic load_out;
	} cmd_t;

endpackage

// ===== src/obrb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obrb_ctrl
// Sequencer: takes one operation, lets the datapath execute it, then loads
// the result register once the output slot is free.
// ----------------------------------------------------------------------------
module obrb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output obrb_pkg::cmd_t cmd
);
	import obrb_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		cmd.exec     = in_valid && (state_q == ST_IDLE);
		cmd.load_out = (state_q == ST_EXEC) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_exec_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> (state_q == ST_EXEC))
		else $error("accepted transfer did not enter execute");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("result load did not raise out_valid");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.exec && cmd.load_out))
		else $error("accept and result load in the same cycle");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("stalled result dropped");

endmodule

// ===== src/obrb_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obrb_dp
// Datapath: slot memory, wrapping pointers, full flag, capacity register and
// the result register.
// ----------------------------------------------------------------------------
module obrb_dp #(
	parameter int DEPTH = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  obrb_pkg::cmd_t                  cmd,
	input  logic [1:0]                      opcode,
	input  logic [obrb_pkg::BYTE_W-1:0]     data_in,
	input  logic                            cap_we,
	input  logic [obrb_pkg::CAP_W-1:0]      cap_wdata,
	output logic [obrb_pkg::CAP_W-1:0]      cap_rdata,
	output logic [obrb_pkg::BYTE_W-1:0]     data_out,
	output logic                            status,
	output logic                            overwrote_oldest,
	output logic [obrb_pkg::CAP_W-1:0]      occupancy,
	output logic                            is_full,
	output logic                            is_empty
);
	import obrb_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW = (PW + 1 > CAP_W + 1) ? PW + 1 : CAP_W + 1;

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rdata_q;

	logic [CAP_W-1:0] cap_q;
	logic [PW-1:0]    wp_q;
	logic [PW-1:0]    rp_q;
	logic             full_q;

	logic rd_ok_q;
	logic st_q;
	logic ovw_q;

	logic [CAP_W-1:0] cap_eff;
	logic [XW-1:0]    cap_x;
	logic [XW-1:0]    wp_x;
	logic [XW-1:0]    rp_x;
	logic [XW-1:0]    wp_inc;
	logic [XW-1:0]    rp_inc;
	logic [PW-1:0]    wp_bump;
	logic [PW-1:0]    rp_bump;
	logic [XW-1:0]    held_x;
	logic             empty_now;
	op_t              op;

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CAP_W'(1);
		end else if (int'(cap_q) > DEPTH) begin
			cap_eff = CAP_W'(DEPTH);
		end else begin
			cap_eff = cap_q;
		end
	end

	assign cap_x   = XW'(cap_eff);
	assign wp_x    = XW'(wp_q);
	assign rp_x    = XW'(rp_q);
	assign wp_inc  = wp_x + XW'(1);
	assign rp_inc  = rp_x + XW'(1);
	assign wp_bump = (wp_inc >= cap_x) ? '0 : wp_inc[PW-1:0];
	assign rp_bump = (rp_inc >= cap_x) ? '0 : rp_inc[PW-1:0];

	assign empty_now = !full_q && (wp_q == rp_q);
	assign op        = op_t'(opcode);

	always_comb begin
		if (full_q) begin
			held_x = cap_x;
		end else if (wp_x >= rp_x) begin
			held_x = wp_x - rp_x;
		end else begin
			held_x = cap_x + wp_x - rp_x;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && (op == OP_PUT)) begin
			mem[wp_q] <= data_in;
		end
		if (cmd.exec && (op == OP_GET)) begin
			rdata_q <= mem[rp_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_RESET;
			wp_q   <= '0;
			rp_q   <= '0;
			full_q <= 1'b0;
		end else if (cap_we) begin
			cap_q  <= cap_wdata;
			wp_q   <= '0;
			rp_q   <= '0;
			full_q <= 1'b0;
		end else if (cmd.exec) begin
			unique case (op)
				OP_PUT: begin
					wp_q <= wp_bump;
					if (full_q) begin
						rp_q   <= rp_bump;
						full_q <= (wp_bump == rp_bump);
					end else begin
						full_q <= (wp_bump == rp_q);
					end
				end
				OP_GET: begin
					if (!empty_now) begin
						rp_q   <= rp_bump;
						full_q <= 1'b0;
					end
				end
				OP_CLEAR: begin
					wp_q   <= '0;
					rp_q   <= '0;
					full_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rd_ok_q <= (op == OP_GET) && !empty_now;
			st_q    <= (op == OP_GET) && empty_now;
			ovw_q   <= (op == OP_PUT) && full_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			data_out         <= rd_ok_q ? rdata_q : '0;
			status           <= st_q;
			overwrote_oldest <= ovw_q;
			occupancy        <= held_x[CAP_W-1:0];
			is_full          <= full_q;
			is_empty         <= empty_now;
		end
	end

	assign cap_rdata = cap_q;

endmodule

// ===== src/overwriting_byte_ring_buffer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_byte_ring_buffer_core
// Byte ring buffer that overwrites its oldest byte when full.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries opcode and data_in: put, get or
// clear. Output channel (out_valid/out_ready) returns one result per
// operation: data_out, status, overwrote_oldest, occupancy, is_full and
// is_empty after the operation.
// Each operation is first executed against the pointers and the slot
// memory, whose read port is registered, and then loaded into the result
// register. No new operation is taken while one is executing, but the next
// operation is taken while the previous result waits in the output register.
// When the receiver stalls, the result is held and a second operation stalls
// in execute until the output register frees.
// The capacity register (byte address 0 on the APB port) sets the wrap point;
// writing it empties the buffer. Reset empties the buffer and sets the
// capacity to 256. Slot contents are not cleared.
// ----------------------------------------------------------------------------
module overwriting_byte_ring_buffer_core #(
	parameter int DEPTH = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [obrb_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [obrb_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [obrb_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          opcode,
	input  logic [obrb_pkg::BYTE_W-1:0]         data_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [obrb_pkg::BYTE_W-1:0]         data_out,
	output logic                                status,
	output logic                                overwrote_oldest,
	output logic [obrb_pkg::CAP_W-1:0]          occupancy,
	output logic                                is_full,
	output logic                                is_empty
);
	import obrb_pkg::*;

	cmd_t             cmd;
	logic             cap_we;
	logic [CAP_W-1:0] cap_rdata;

	assign pready = 1'b1;
	assign cap_we = psel && penable && pwrite && (paddr == ADDR_CAPACITY);

	always_comb begin
		if (paddr == ADDR_CAPACITY) begin
			prdata = APB_DATA_W'(cap_rdata);
		end else begin
			prdata = '0;
		end
	end

	obrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	obrb_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.opcode           (opcode),
		.data_in          (data_in),
		.cap_we           (cap_we),
		.cap_wdata        (pwdata[CAP_W-1:0]),
		.cap_rdata        (cap_rdata),
		.data_out         (data_out),
		.status           (status),
		.overwrote_oldest (overwrote_oldest),
		.occupancy        (occupancy),
		.is_full          (is_full),
		.is_empty         (is_empty)
	);

endmodule
